// ===== rtl/jac_pkg.sv =====
// ----------------------------------------------------------------------------
// jac_pkg: shared types and constants for the joint angle chain
// Segment codes, datapath widths and the arctangent step table used by the
// tilt-to-joint-angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package jac_pkg;

   // segment selector carried on the request side
   typedef enum logic [1:0] {
      MODE_ANKLE   = 2'd0,
      MODE_KNEE    = 2'd1,
      MODE_HIP     = 2'd2,
      MODE_INVALID = 2'd3
   } mode_type;

   localparam int ATAN_ITERATIONS_DEF = 16;
   localparam int ATAN_MAX            = 24;   // entries in the step table
   localparam int CNT_W               = 5;    // indexes up to ATAN_MAX-1
   localparam int MAG_W               = 16;   // axis magnitude, 0..32768
   localparam int VEC_SHIFT           = 24;   // vector start scale 2^24
   localparam int VEC_W               = 44;   // signed CORDIC x/y width
   localparam int ACC_W               = 30;   // signed angle accumulator
   localparam int ACC_FRAC            = 20;   // accumulator units of 2^-20 deg
   localparam int DEG_W               = ACC_W - ACC_FRAC;
   localparam int TILT_W              = 7;    // whole-degree tilt, 0..89
   localparam int ANG_W               = 11;
   localparam int ATILT_W             = 8;
   localparam int STILT_W             = 10;
   localparam int CALC_W              = 12;   // headroom for angle sums

   localparam logic [TILT_W-1:0] TILT_MAX  = 7'd89;
   localparam logic [TILT_W-1:0] TILT_DIAG = 7'd45;

   // atan(2^-i) in units of 2^-20 degree, rounded to nearest
   function automatic logic [ACC_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
      logic [ACC_W-1:0] val;
      unique case (idx)
         5'd0:    val = 30'd47185920;
         5'd1:    val = 30'd27855475;
         5'd2:    val = 30'd14718068;
         5'd3:    val = 30'd7471121;
         5'd4:    val = 30'd3750058;
         5'd5:    val = 30'd1876857;
         5'd6:    val = 30'd938658;
         5'd7:    val = 30'd469357;
         5'd8:    val = 30'd234682;
         5'd9:    val = 30'd117342;
         5'd10:   val = 30'd58671;
         5'd11:   val = 30'd29335;
         5'd12:   val = 30'd14668;
         5'd13:   val = 30'd7334;
         5'd14:   val = 30'd3667;
         5'd15:   val = 30'd1833;
         5'd16:   val = 30'd917;
         5'd17:   val = 30'd458;
         5'd18:   val = 30'd229;
         5'd19:   val = 30'd115;
         5'd20:   val = 30'd57;
         5'd21:   val = 30'd29;
         5'd22:   val = 30'd14;
         5'd23:   val = 30'd7;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/joint_angle_chain_from_tilt.sv =====
// ----------------------------------------------------------------------------
// joint_angle_chain_from_tilt: accelerometer tilt to chained joint angle
// One sample in, one joint angle out; an iterative CORDIC arctangent feeds
// the ankle, knee and hip chain with its stored tilts.
// ----------------------------------------------------------------------------
`default_nettype none

// An item whose second axis and x are both nonzero under a valid segment is
// loaded on acceptance, then rotated one CORDIC step per cycle through a single
// shared shift/add/subtract stage, and finally has its tilt chained into the
// angle before the block is ready again. Error items and zero-axis fallbacks
// skip the rotations.
// The result sits in an output register, so the next item is taken while a
// finished result still waits on rsp_tready; the block stalls only when a
// second result is ready before the first has been taken.
module joint_angle_chain_from_tilt
   import jac_pkg::*;
#(
   parameter int ATAN_ITERATIONS = ATAN_ITERATIONS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // accel_x_in[15:0], accel_y_in[31:16], accel_z_in[47:32]
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // angle_deg[10:0], zero fill [15:11]
   output logic             rsp_tuser    // error[0]
);

   localparam int ITER_COUNT = (ATAN_ITERATIONS < ATAN_MAX) ? ATAN_ITERATIONS : ATAN_MAX;
   localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(ITER_COUNT - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ITER,
      S_FINISH
   } state_type;

   // control
   state_type               state_ff,   state_in;
   logic [CNT_W-1:0]        cnt_ff,     cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ANG_W-1:0]   ankle_angle_ff, ankle_angle_in;
   logic signed [ATILT_W-1:0] ankle_tilt_ff,  ankle_tilt_in;
   logic signed [STILT_W-1:0] shank_tilt_ff,  shank_tilt_in;

   // payload
   mode_type                mode_ff,    mode_in;
   logic                    xneg_ff,    xneg_in;
   logic                    spos_ff,    spos_in;
   logic                    szero_ff,   szero_in;
   logic                    err_ff,     err_in;
   logic                    diag_ff,    diag_in;
   logic signed [VEC_W-1:0] vx_ff,      vx_in;
   logic signed [VEC_W-1:0] vy_ff,      vy_in;
   logic signed [ACC_W-1:0] acc_ff,     acc_in;
   logic signed [ANG_W-1:0] angle_ff,   angle_in;
   logic                    rsp_err_ff, rsp_err_in;

   // input decode
   logic signed [15:0] ax, ay, az, sec;
   logic [MAG_W-1:0]   mag_x, mag_s;
   mode_type           mode_req;
   logic               err_req;

   // CORDIC step
   logic signed [VEC_W-1:0] vx_sh, vy_sh;
   logic signed [ACC_W-1:0] step_ang;

   // chaining
   logic [DEG_W-1:0]         deg;
   logic [TILT_W-1:0]        tilt;
   logic signed [CALC_W-1:0] t12, aa12, at12, st12, ang12;
   logic                     out_free;

   assign ax       = $signed(req_tdata[15:0]);
   assign ay       = $signed(req_tdata[31:16]);
   assign az       = $signed(req_tdata[47:32]);
   assign mode_req = mode_type'(req_tuser);
   assign sec      = (mode_req == MODE_HIP) ? az : ay;
   assign mag_x    = ax[15]  ? MAG_W'(-ax)  : MAG_W'(ax);
   assign mag_s    = sec[15] ? MAG_W'(-sec) : MAG_W'(sec);
   assign err_req  = (ax == 16'sd0) || (mode_req == MODE_INVALID);

   assign vx_sh    = vx_ff >>> cnt_ff;
   assign vy_sh    = vy_ff >>> cnt_ff;
   assign step_ang = $signed(atan_entry(cnt_ff));

   // whole degrees, truncated; negative accumulator reads as zero, above 89 saturates, equal magnitudes give 45
   assign deg  = DEG_W'(acc_ff >>> ACC_FRAC);
   always_comb begin
      priority if (diag_ff) begin
         tilt = TILT_DIAG;
      end else if (acc_ff[ACC_W-1]) begin
         tilt = '0;
      end else if (deg > DEG_W'(TILT_MAX)) begin
         tilt = TILT_MAX;
      end else begin
         tilt = TILT_W'(deg);
      end
   end

   assign t12  = $signed({{(CALC_W-TILT_W){1'b0}}, tilt});
   assign aa12 = CALC_W'(ankle_angle_ff);
   assign at12 = CALC_W'(ankle_tilt_ff);
   assign st12 = CALC_W'(shank_tilt_ff);

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      ankle_angle_in = ankle_angle_ff;
      ankle_tilt_in  = ankle_tilt_ff;
      shank_tilt_in  = shank_tilt_ff;
      mode_in        = mode_ff;
      xneg_in        = xneg_ff;
      spos_in        = spos_ff;
      szero_in       = szero_ff;
      err_in         = err_ff;
      diag_in        = diag_ff;
      vx_in          = vx_ff;
      vy_in          = vy_ff;
      acc_in         = acc_ff;
      angle_in       = angle_ff;
      rsp_err_in     = rsp_err_ff;
      ang12          = -12'sd1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = mode_req;
               xneg_in  = ax[15];
               spos_in  = !sec[15] && (sec != 16'sd0);
               szero_in = (sec == 16'sd0);
               err_in   = err_req;
               diag_in  = (mag_x == mag_s);
               vx_in    = $signed({{(VEC_W-MAG_W-VEC_SHIFT){1'b0}}, mag_x, {VEC_SHIFT{1'b0}}});
               vy_in    = $signed({{(VEC_W-MAG_W-VEC_SHIFT){1'b0}}, mag_s, {VEC_SHIFT{1'b0}}});
               acc_in   = '0;
               cnt_in   = '0;
               state_in = (err_req || sec == 16'sd0) ? S_FINISH : S_ITER;
            end
         end
         S_ITER: begin
            // rotate toward the x axis, one step per cycle
            if (!vy_ff[VEC_W-1]) begin
               vx_in  = vx_ff + vy_sh;
               vy_in  = vy_ff - vx_sh;
               acc_in = acc_ff + step_ang;
            end else begin
               vx_in  = vx_ff - vy_sh;
               vy_in  = vy_ff + vx_sh;
               acc_in = acc_ff - step_ang;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ITER_LAST) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               if (err_ff) begin
                  ang12 = -12'sd1;
               end else begin
                  unique case (mode_ff)
                     MODE_ANKLE: begin
                        if (szero_ff) begin
                           ang12 = 12'sd90;
                        end else begin
                           if (xneg_ff) begin
                              ang12 = spos_ff ? (12'sd90 + t12) : (12'sd90 - t12);
                              ankle_tilt_in = ATILT_W'(t12);
                           end else begin
                              ang12 = spos_ff ? (12'sd270 - t12) : (t12 - 12'sd90);
                              ankle_tilt_in = ATILT_W'(-t12);
                           end
                           ankle_angle_in = ANG_W'(ang12);
                        end
                     end
                     MODE_KNEE: begin
                        if (szero_ff) begin
                           ang12 = 12'sd180 - (st12 + at12);
                        end else if (xneg_ff) begin
                           ang12 = spos_ff ? (aa12 + 12'sd90 - t12) : (aa12 + 12'sd90 + t12);
                           shank_tilt_in = STILT_W'(t12);
                        end else if (spos_ff) begin
                           ang12 = aa12 - 12'sd90 + t12;
                           shank_tilt_in = STILT_W'(12'sd180 - t12);
                        end else begin
                           ang12 = aa12 - 12'sd90 - t12;
                           shank_tilt_in = STILT_W'(-t12);
                        end
                     end
                     MODE_HIP: begin
                        if (szero_ff) begin
                           ang12 = 12'sd180 - st12;
                        end else if (xneg_ff) begin
                           ang12 = t12 - st12;
                        end else begin
                           ang12 = spos_ff ? (12'sd180 - st12 + t12)
                                           : (12'sd180 - st12 - t12);
                        end
                     end
                     default: begin
                        ang12 = -12'sd1;
                     end
                  endcase
               end
               angle_in     = ANG_W'(ang12);
               rsp_err_in   = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         ankle_angle_ff <= '0;
         ankle_tilt_ff  <= '0;
         shank_tilt_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         ankle_angle_ff <= ankle_angle_in;
         ankle_tilt_ff  <= ankle_tilt_in;
         shank_tilt_ff  <= shank_tilt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      xneg_ff    <= xneg_in;
      spos_ff    <= spos_in;
      szero_ff   <= szero_in;
      err_ff     <= err_in;
      diag_ff    <= diag_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      acc_ff     <= acc_in;
      angle_ff   <= angle_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-ANG_W){1'b0}}, angle_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

// ===== bench/joint_angle_chain_from_tilt_checker.sv =====
// ----------------------------------------------------------------------------
// joint_angle_chain_from_tilt_checker: scoreboard for the joint angle chain
// Watches both streams, predicts each joint angle from the accepted sample
// with its own CORDIC arctangent and stored tilts, and compares every result
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_angle_chain_from_tilt_checker
   import jac_pkg::*;
#(
   parameter int ITERS = ATAN_ITERATIONS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,   // accel_x_in[15:0], accel_y_in[31:16], accel_z_in[47:32]
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // angle_deg[10:0], zero fill [15:11]
   input  wire logic        rsp_tuser,   // error[0]
   output int               fail_count,
   output int               pending,
   output int               checked
);

   typedef struct packed {
      logic [10:0] angle;
      logic        err;
   } angle_result_t;

   // atan(2^-i) in 2^-20 degree units
   localparam longint ATAN_STEP [24] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7
   };

   logic signed [10:0] ankle_ang_q;
   logic signed [7:0]  ankle_tilt_q;
   logic signed [9:0]  shank_tilt_q;
   angle_result_t      expected_angles [$];

   function automatic longint axis_mag(input logic signed [15:0] v);
      return (v < 0) ? -longint'(v) : longint'(v);
   endfunction

   // whole degrees of atan(n/d), truncated toward zero, saturated at 89
   function automatic int tilt_from_axes(input longint n, input longint d);
      longint vx;
      longint vy;
      longint acc;
      longint sx;
      longint sy;
      int     i;
      if (n == d) return 45;
      vx  = d * 16777216;
      vy  = n * 16777216;
      acc = 0;
      for (i = 0; i < ITERS && i < 24; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (vy >= 0) begin
            vx  = vx + sy;
            vy  = vy - sx;
            acc = acc + ATAN_STEP[i];
         end else begin
            vx  = vx - sy;
            vy  = vy + sx;
            acc = acc - ATAN_STEP[i];
         end
      end
      if (acc < 0) return 0;
      acc = acc >>> 20;
      if (acc > 89) acc = 89;
      return int'(acc);
   endfunction

   // one sample in, one joint angle out; updates the stored tilts
   function automatic angle_result_t joint_angle_predict(input mode_type seg,
                                                         input logic signed [15:0] ax,
                                                         input logic signed [15:0] ay,
                                                         input logic signed [15:0] az);
      angle_result_t res;
      int            ang;
      int            t;
      ang     = -1;
      res.err = 1'b0;
      if (ax == 0 || seg == MODE_INVALID) begin
         res.err = 1'b1;
      end else begin
         case (seg)
            MODE_ANKLE: begin
               if (ay == 0) begin
                  ang = 90;
               end else begin
                  t = tilt_from_axes(axis_mag(ay), axis_mag(ax));
                  if (ax < 0) begin
                     ang          = (ay > 0) ? 90 + t : 90 - t;
                     ankle_tilt_q = 8'(t);
                  end else begin
                     ang          = (ay > 0) ? 270 - t : t - 90;
                     ankle_tilt_q = 8'(-t);
                  end
                  ankle_ang_q = 11'(ang);
               end
            end
            MODE_KNEE: begin
               if (ay == 0) begin
                  ang = 180 - (shank_tilt_q + ankle_tilt_q);
               end else begin
                  t = tilt_from_axes(axis_mag(ay), axis_mag(ax));
                  if (ax < 0) begin
                     ang          = (ay > 0) ? ankle_ang_q + 90 - t : ankle_ang_q + 90 + t;
                     shank_tilt_q = 10'(t);
                  end else if (ay > 0) begin
                     ang          = ankle_ang_q - 90 + t;
                     shank_tilt_q = 10'(180 - t);
                  end else begin
                     ang          = ankle_ang_q - 90 - t;
                     shank_tilt_q = 10'(-t);
                  end
               end
            end
            default: begin
               // hip stores nothing; zero z falls back to the shank tilt
               if (az == 0) begin
                  ang = 180 - shank_tilt_q;
               end else begin
                  t = tilt_from_axes(axis_mag(az), axis_mag(ax));
                  if (ax > 0)
                     ang = (az > 0) ? 180 - shank_tilt_q + t : 180 - shank_tilt_q - t;
                  else
                     ang = t - shank_tilt_q;
               end
            end
         endcase
      end
      res.angle = 11'(ang);
      return res;
   endfunction

   always @(posedge clock) begin
      angle_result_t want;
      angle_result_t got;
      if (reset) begin
         ankle_ang_q  = '0;
         ankle_tilt_q = '0;
         shank_tilt_q = '0;
         expected_angles.delete();
         fail_count   = 0;
         checked      = 0;
         pending     <= 0;
      end else begin
         // check first: a result never belongs to the item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.angle = rsp_tdata[10:0];
            got.err   = rsp_tuser;
            if (expected_angles.size() == 0) begin
               $error("result with no sample waiting: angle_deg %0d error %0b",
                      $signed(got.angle), got.err);
               fail_count++;
            end else begin
               want = expected_angles.pop_front();
               checked++;
               if (got.angle !== want.angle) begin
                  $error("angle_deg: expected %0d, actual %0d",
                         $signed(want.angle), $signed(got.angle));
                  fail_count++;
               end
               if (got.err !== want.err) begin
                  $error("error: expected %0b, actual %0b", want.err, got.err);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_angles.push_back(joint_angle_predict(mode_type'(req_tuser),
                                                          req_tdata[15:0],
                                                          req_tdata[31:16],
                                                          req_tdata[47:32]));
         pending <= expected_angles.size();
      end
   end

endmodule

`default_nettype wire

// ===== bench/joint_angle_chain_from_tilt_tb.sv =====
// ----------------------------------------------------------------------------
// joint_angle_chain_from_tilt_tb: stimulus and verdict for the joint angle chain
// Drives directed corner samples, then chained ankle/knee/hip sequences with
// random readings and some noise, under random gaps and stalls on both sides,
// one long output stall and a full drain midway; the checker scores every result.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_angle_chain_from_tilt_tb;
   import jac_pkg::*;

   localparam int ITERS      = ATAN_ITERATIONS_DEF;
   localparam int TOTAL      = 850;
   localparam int LONG_HOLD  = 300;
   localparam int IDLE_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // accel_x_in[15:0], accel_y_in[31:16], accel_z_in[47:32]
   logic [1:0]  req_tuser;    // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // angle_deg[10:0], zero fill [15:11]
   logic        rsp_tuser;    // error[0]

   int fail_count;
   int pending;
   int checked;
   int sent;
   int idle_max;
   int idle_cycles;
   int mode_sent [4];
   bit long_hold_req;

   joint_angle_chain_from_tilt #(.ATAN_ITERATIONS(ITERS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   joint_angle_chain_from_tilt_checker #(.ITERS(ITERS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // bias toward extremes and small values, zero included
   function automatic logic [15:0] pick_axis();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6)  return 16'h8000;
      if (r < 12) return 16'h7fff;
      if (r < 16) return 16'h0001;
      if (r < 20) return 16'hffff;
      if (r < 35) return 16'($urandom_range(0, 400) - 200);
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_nonzero();
      logic [15:0] v;
      do v = pick_axis(); while (v == 16'h0000);
      return v;
   endfunction

   // second axis for a well-formed sample: rarely zero, sometimes equal magnitude
   function automatic logic [15:0] pick_second(input logic [15:0] x);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return 16'h0000;
      if (r < 12) return ($urandom_range(0, 1) != 0) ? x : 16'(-x);
      return pick_nonzero();
   endfunction

   task automatic send_sample(input mode_type m, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      sent++;
      mode_sent[int'(m)]++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending != 0);
   endtask

   // receiver: random stall per item, one long hold on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = $urandom_range(0, idle_max);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            n = LONG_HOLD;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("joint_angle_chain_from_tilt_tb failed");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] x;
      int          next_phase;
      bit          held;
      bit          drained;
      mode_type    m;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = MODE_ANKLE;
      idle_max      = 6;
      idle_cycles   = 0;
      long_hold_req = 1'b0;
      sent          = 0;
      held          = 1'b0;
      drained       = 1'b0;
      next_phase    = 120;
      mode_sent     = '{default: 0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fallbacks on reset state, zero x in every segment, invalid mode
      send_sample(MODE_KNEE,    16'd5,      16'd0,      16'd0);
      send_sample(MODE_HIP,     -16'sd7,    16'd0,      16'd0);
      send_sample(MODE_ANKLE,   16'd0,      16'd100,    16'd3);
      send_sample(MODE_KNEE,    16'd0,      -16'sd100,  16'd3);
      send_sample(MODE_HIP,     16'd0,      16'd9,      16'h8000);
      send_sample(MODE_INVALID, 16'd100,    16'd50,     16'd50);
      // ankle quadrants, equal magnitudes, tilt at 0 and 89
      send_sample(MODE_ANKLE,   16'h8000,   16'h7fff,   16'd0);
      send_sample(MODE_ANKLE,   16'h8000,   16'h8000,   16'd0);
      send_sample(MODE_ANKLE,   16'h7fff,   16'd1,      16'd0);
      send_sample(MODE_ANKLE,   16'd1,      16'h8000,   16'd0);
      send_sample(MODE_ANKLE,   16'h7fff,   16'h8000,   16'hffff);
      send_sample(MODE_ANKLE,   16'hffff,   16'd0,      16'd0);
      // knee quadrants and zero-y fallback on live tilts
      send_sample(MODE_KNEE,    -16'sd3,    16'd4,      16'd0);
      send_sample(MODE_KNEE,    16'h8000,   16'hffff,   16'd0);
      send_sample(MODE_KNEE,    16'd200,    16'd200,    16'd0);
      send_sample(MODE_KNEE,    16'd9,      16'h8000,   16'd0);
      send_sample(MODE_KNEE,    -16'sd2,    16'd0,      16'd0);
      // hip quadrants and zero-z fallback
      send_sample(MODE_HIP,     16'h7fff,   16'd0,      16'h7fff);
      send_sample(MODE_HIP,     16'd1,      16'd0,      16'h8000);
      send_sample(MODE_HIP,     16'h8000,   16'd0,      16'd5);
      send_sample(MODE_HIP,     -16'sd5,    16'd0,      -16'sd5);
      send_sample(MODE_HIP,     16'd3,      16'hffff,   16'd0);
      send_sample(MODE_INVALID, 16'h8000,   16'd0,      16'd0);
      send_sample(MODE_ANKLE,   16'h8000,   16'h7fff,   16'hffff);

      while (sent < TOTAL) begin
         if (sent >= next_phase) begin
            idle_max   = (idle_max == 0) ? 6 : 0;
            next_phase = next_phase + 120;
         end
         if (!held && sent >= 300) begin
            held          = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!drained && sent >= 600) begin
            drained = 1'b1;
            // drop the last item so it is not taken again while draining
            req_tvalid <= 1'b0;
            wait_drained();
         end
         if ($urandom_range(0, 9) < 8) begin
            x = pick_nonzero();
            send_sample(MODE_ANKLE, x, pick_second(x), pick_axis());
            x = pick_nonzero();
            send_sample(MODE_KNEE, x, pick_second(x), pick_axis());
            x = pick_nonzero();
            send_sample(MODE_HIP, x, pick_axis(), pick_second(x));
         end else begin
            m = mode_type'($urandom_range(0, 3));
            send_sample(m, pick_axis(), pick_axis(), pick_axis());
         end
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (4 * (ITERS + 2)) @(posedge clock);

      $display("covered %0d samples: ankle %0d, knee %0d, hip %0d, invalid %0d",
               sent, mode_sent[0], mode_sent[1], mode_sent[2], mode_sent[3]);
      $display("%0d results checked under random stalls, one long hold and one drain",
               checked);
      if (fail_count == 0)
         $display("joint_angle_chain_from_tilt_tb passed");
      else
         $display("joint_angle_chain_from_tilt_tb failed");
      $finish;
   end

endmodule

`default_nettype wire
